/* rtl/swd_pkg.sv */
// ----------------------------------------------------------------------------
// swd_pkg
// Shared types, constants and helpers for the sync word deframer.
// ----------------------------------------------------------------------------
package swd_pkg;

  // Sync words and their reset values
  localparam int unsigned SYNC_W = 32;
  localparam logic [SYNC_W-1:0] RESET_CMD_SYNC = 32'h55AA55AA;
  localparam logic [SYNC_W-1:0] RESET_PAY_SYNC = 32'hA55A3CC3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_SYNC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAY_SYNC = 1'd1;

  // Frame geometry
  localparam int unsigned DEF_PAYLOAD_BYTES = 64;
  localparam int unsigned CMD_FRAME_BITS = 24;
  localparam int unsigned CMD_CRC_BITS = 16;   // id + value are covered by the CRC
  localparam int unsigned BYTE_IDX_W = 6;

  // CRC-8 and dewhitening constants
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] WHITEN_MUL = 8'd211;
  localparam logic [7:0] WHITEN_ADD = 8'd79;

  // Result kinds
  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_PAY = 1'b1;

  // Frame mode
  typedef enum logic [1:0] {
    MODE_HUNT = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_PAY  = 2'd2
  } mode_t;

  // Sync comparator outcome
  typedef struct packed {
    logic hit;      // some pattern matched
    logic is_pay;   // payload frame follows
    logic inv;      // matched through an inverted word
  } sync_hit_t;

  // One result word
  typedef struct packed {
    logic                  kind;
    logic [7:0]            cmd_id;
    logic [7:0]            cmd_value;
    logic [7:0]            pay_byte;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic                  last;
    logic                  inverted;
  } result_t;

  // One MSB-first step of CRC-8
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic b);
    logic [7:0] sh;
    sh = {crc[6:0], 1'b0};
    return (crc[7] ^ b) ? (sh ^ CRC_POLY) : sh;
  endfunction

endpackage

/* rtl/swd_sync_match.sv */
// ----------------------------------------------------------------------------
// swd_sync_match
// Compares the hunt shift register against both sync words and inverses.
// ----------------------------------------------------------------------------
module swd_sync_match import swd_pkg::*; (
  input  logic [SYNC_W-1:0] shift_val,
  input  logic [SYNC_W-1:0] cmd_sync,
  input  logic [SYNC_W-1:0] pay_sync,
  output sync_hit_t         hit
);

  // Priority: command, inverse command, payload, inverse payload
  always_comb begin
    hit = '0;
    if (shift_val == cmd_sync) begin
      hit.hit = 1'b1;
    end else if (shift_val == ~cmd_sync) begin
      hit.hit = 1'b1;
      hit.inv = 1'b1;
    end else if (shift_val == pay_sync) begin
      hit.hit    = 1'b1;
      hit.is_pay = 1'b1;
    end else if (shift_val == ~pay_sync) begin
      hit.hit    = 1'b1;
      hit.is_pay = 1'b1;
      hit.inv    = 1'b1;
    end
  end

endmodule

/* rtl/swd_deframe.sv */
// ----------------------------------------------------------------------------
// swd_deframe
// Frame state and per-bit datapath: hunting, command frame with serial
// CRC-8, payload bytes with dewhitening.
// ----------------------------------------------------------------------------
module swd_deframe import swd_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,    // process in_bit this cycle
  input  logic              in_bit,
  input  logic [SYNC_W-1:0] cmd_sync,
  input  logic [SYNC_W-1:0] pay_sync,
  output logic              res_valid,
  output result_t           res
);

  localparam int unsigned MAX_BITS =
    (PAYLOAD_BYTES * 8 > CMD_FRAME_BITS) ? PAYLOAD_BYTES * 8 : CMD_FRAME_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_BITS + 1);
  localparam logic [CNT_W-1:0] CMD_END = CNT_W'(CMD_FRAME_BITS);
  localparam logic [CNT_W-1:0] CRC_END = CNT_W'(CMD_CRC_BITS);
  localparam logic [CNT_W-1:0] PAY_END = CNT_W'(PAYLOAD_BYTES * 8);

  // State registers
  mode_t                       mode, mode_next;
  logic [SYNC_W-1:0]           sync_shift, sync_shift_next;
  logic [CNT_W-1:0]            bit_counter, bit_counter_next;
  logic [CMD_FRAME_BITS-1:0]   cmd_shift, cmd_shift_next;
  logic [7:0]                  byte_shift, byte_shift_next;
  logic [7:0]                  crc, crc_next;
  logic                        invert_flag, invert_flag_next;

  logic [SYNC_W-1:0]           sync_cand;
  sync_hit_t                   hit;
  logic                        bit_c;
  logic [CNT_W-1:0]            cnt_inc;
  logic                        cmd_done;
  logic                        crc_ok;
  logic                        byte_done;
  logic                        pay_last;
  logic [8:0]                  idx_full;
  logic [7:0]                  whiten;

  assign sync_cand = {sync_shift[SYNC_W-2:0], in_bit};

  swd_sync_match u_match (
    .shift_val (sync_cand),
    .cmd_sync  (cmd_sync),
    .pay_sync  (pay_sync),
    .hit       (hit)
  );

  // Frame events
  always_comb begin
    bit_c     = in_bit ^ invert_flag;
    cnt_inc   = bit_counter + CNT_W'(1);
    cmd_done  = (cnt_inc == CMD_END);
    crc_ok    = (crc == {cmd_shift[6:0], bit_c});
    byte_done = (cnt_inc[2:0] == 3'd0);
    pay_last  = (cnt_inc == PAY_END);
    idx_full  = 9'(cnt_inc >> 3) - 9'd1;
    whiten    = 8'(idx_full[7:0] * WHITEN_MUL) + WHITEN_ADD;
  end

  // Next frame mode
  always_comb begin
    mode_next = mode;
    case (mode)
      MODE_CMD: begin
        if (cmd_done) mode_next = MODE_HUNT;
      end
      MODE_PAY: begin
        if (byte_done && pay_last) mode_next = MODE_HUNT;
      end
      default: begin
        if (hit.hit) mode_next = hit.is_pay ? MODE_PAY : MODE_CMD;
      end
    endcase
  end

  // Datapath updates and result
  always_comb begin
    sync_shift_next  = sync_shift;
    bit_counter_next = bit_counter;
    cmd_shift_next   = cmd_shift;
    byte_shift_next  = byte_shift;
    crc_next         = crc;
    invert_flag_next = invert_flag;
    res_valid        = 1'b0;
    res              = '0;
    case (mode)
      MODE_CMD: begin
        cmd_shift_next   = {cmd_shift[CMD_FRAME_BITS-2:0], bit_c};
        bit_counter_next = cnt_inc;
        if (bit_counter < CRC_END) crc_next = crc8_step(crc, bit_c);
        if (cmd_done) begin
          res_valid        = crc_ok;
          res.kind         = KIND_CMD;
          res.cmd_id       = cmd_shift[22:15];
          res.cmd_value    = cmd_shift[14:7];
          res.inverted     = invert_flag;
          bit_counter_next = '0;
          cmd_shift_next   = '0;
          byte_shift_next  = '0;
          crc_next         = '0;
          sync_shift_next  = '0;
        end
      end
      MODE_PAY: begin
        byte_shift_next  = {byte_shift[6:0], bit_c};
        bit_counter_next = cnt_inc;
        if (byte_done) begin
          res_valid       = 1'b1;
          res.kind        = KIND_PAY;
          res.pay_byte    = {byte_shift[6:0], bit_c} ^ whiten;
          res.byte_index  = idx_full[BYTE_IDX_W-1:0];
          res.last        = pay_last;
          res.inverted    = invert_flag;
          byte_shift_next = '0;
          if (pay_last) begin
            bit_counter_next = '0;
            cmd_shift_next   = '0;
            crc_next         = '0;
            sync_shift_next  = '0;
          end
        end
      end
      default: begin
        sync_shift_next = sync_cand;
        if (hit.hit) begin
          invert_flag_next = hit.inv;
          bit_counter_next = '0;
          cmd_shift_next   = '0;
          byte_shift_next  = '0;
          crc_next         = '0;
        end
      end
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_HUNT;
      sync_shift  <= '0;
      bit_counter <= '0;
      cmd_shift   <= '0;
      byte_shift  <= '0;
      crc         <= '0;
      invert_flag <= 1'b0;
    end else if (step_en) begin
      mode        <= mode_next;
      sync_shift  <= sync_shift_next;
      bit_counter <= bit_counter_next;
      cmd_shift   <= cmd_shift_next;
      byte_shift  <= byte_shift_next;
      crc         <= crc_next;
      invert_flag <= invert_flag_next;
    end
  end

  // Checks
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HUNT || mode == MODE_CMD || mode == MODE_PAY))
    else $error("frame mode out of range");

  a_cmd_count_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_CMD) |-> (bit_counter < CMD_END))
    else $error("command bit count out of range");

  a_frame_end_hunts: assert property (@(posedge clk) disable iff (rst)
    (step_en && res_valid && (res.kind == KIND_CMD || res.last)) |=>
      (mode == MODE_HUNT && bit_counter == '0))
    else $error("block did not return to hunting after a frame");

  a_result_in_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (mode == MODE_CMD || mode == MODE_PAY))
    else $error("result raised while hunting");

endmodule

/* rtl/swd_out_reg.sv */
// ----------------------------------------------------------------------------
// swd_out_reg
// Result register on the master-side stream; packs the result word.
// ----------------------------------------------------------------------------
module swd_out_reg import swd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load_en,   // a processed bit arrives this cycle
  input  logic        res_valid,
  input  result_t     res,
  output logic        can_load,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // command_id, command_value, payload_byte, byte_index
  output logic [1:0]  m_tuser,   // result_kind, frame_inverted
  output logic        m_tlast    // last_byte
);

  result_t held;

  // Free when empty or when the held word leaves this cycle
  assign can_load = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (can_load) begin
      m_tvalid <= load_en && res_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (can_load && load_en && res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {2'b00, held.byte_index, held.pay_byte, held.cmd_value, held.cmd_id};
  assign m_tuser = {held.inverted, held.kind};
  assign m_tlast = held.last;

endmodule

/* rtl/sync_word_deframer_with_crc_check.sv */
// ----------------------------------------------------------------------------
// sync_word_deframer_with_crc_check
// Bit-serial sync word deframer with CRC-8 command check and payload
// dewhitening.
// ----------------------------------------------------------------------------
// Takes one demodulated bit per input word and accepts a bit every clock
// cycle while the result side keeps up; each bit is caught in an input
// register and goes through short frame logic into a result register. The
// input stalls only while a result word waits unaccepted and another bit is
// already held. While hunting, the last 32 bits are compared with the
// command and payload sync words and their inverses; an inverse match flips
// all bits of the frame that follows. A command frame (24 bits: id, value,
// CRC-8 poly 0x07 init 0) yields one word only if the CRC matches. A
// payload frame of PAYLOAD_BYTES bytes yields one word per byte, dewhitened
// with (index*211+79) mod 256, the final byte with tlast. Sync words are to
// be written by the user through the cfg port only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sync_word_deframer_with_crc_check import swd_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = DEF_PAYLOAD_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,    // rx_bit
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,    // command_id, command_value, payload_byte, byte_index
  output logic [1:0]           m_tuser,    // result_kind, frame_inverted
  output logic                 m_tlast,    // last_byte
  // Configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SYNC_W-1:0]    cfg_data
);

  logic [SYNC_W-1:0] cmd_sync;
  logic [SYNC_W-1:0] pay_sync;
  logic              in_valid;
  logic              in_bit;
  logic              can_load;
  logic              step_en;
  logic              res_valid;
  result_t           res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_sync <= RESET_CMD_SYNC;
      pay_sync <= RESET_PAY_SYNC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CMD_SYNC: cmd_sync <= cfg_data;
        REG_PAY_SYNC: pay_sync <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  assign step_en  = in_valid && can_load;
  assign s_tready = !in_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_bit <= s_tdata[0];
    end
  end

  swd_deframe #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_deframe (
    .clk       (clk),
    .rst       (rst),
    .step_en   (step_en),
    .in_bit    (in_bit),
    .cmd_sync  (cmd_sync),
    .pay_sync  (pay_sync),
    .res_valid (res_valid),
    .res       (res)
  );

  swd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load_en   (step_en),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the sync word deframer with CRC-8 command check.
// ----------------------------------------------------------------------------
// Demodulated bits are fed one per word through the input stream. The bits
// come from command frames with good and bad CRC, payload frames, plain or
// inverted sync words, and random noise. The sync words are reprogrammed
// between phases: reset values, equal words, extremes and random words. A
// bit-level tracker of the deframer, fed with every accepted bit, predicts
// each result word. The monitor compares every result word field by field
// with the oldest prediction. Both sides idle at random; one long receiver
// hold-off fills the block, and the sender drains fully between phases.
// ----------------------------------------------------------------------------
module tb;
  import swd_pkg::*;

  localparam int unsigned FRAME_BYTES = DEF_PAYLOAD_BYTES;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Payload body styles
  typedef enum logic [1:0] {
    BODY_RANDOM,
    BODY_EXTREMES,
    BODY_SYNC_INSIDE
  } body_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // rx_bit
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;        // command_id, command_value, payload_byte, byte_index
  logic [1:0]           m_tuser;        // result_kind, frame_inverted
  logic                 m_tlast;        // last_byte
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SYNC_W-1:0]    cfg_data = '0;

  sync_word_deframer_with_crc_check #(
    .PAYLOAD_BYTES(FRAME_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Pending bits and result words still owed by the deframer
  logic        rx_bits[$];
  result_t     due_results[$];
  int unsigned frame_bits_sent = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Idle control
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Tracker state
  logic [31:0] cmd_sync = RESET_CMD_SYNC;
  logic [31:0] pay_sync = RESET_PAY_SYNC;
  logic [31:0] sync_reg = '0;
  mode_t       rx_mode = MODE_HUNT;
  int unsigned bits_in_frame = 0;
  logic [23:0] cmd_reg = '0;
  logic [7:0]  byte_reg = '0;
  logic        inv_flag = 1'b0;

  result_t     want;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++)
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic logic [7:0] whiten_mask(input int unsigned idx);
    return 8'(idx * WHITEN_MUL + WHITEN_ADD);
  endfunction

  function automatic void back_to_hunt();
    rx_mode = MODE_HUNT;
    bits_in_frame = 0;
    cmd_reg = '0;
    byte_reg = '0;
    sync_reg = '0;
  endfunction

  // Advance the tracker by one accepted bit, queueing any result word
  function automatic void deframe_bit(input logic raw);
    logic        b;
    logic [7:0]  id;
    logic [7:0]  val;
    int unsigned idx;
    result_t     r;
    b = raw ^ inv_flag;
    r = '0;
    r.inverted = inv_flag;
    case (rx_mode)
      MODE_CMD: begin
        cmd_reg = {cmd_reg[22:0], b};
        bits_in_frame++;
        if (bits_in_frame >= CMD_FRAME_BITS) begin
          id = cmd_reg[23:16];
          val = cmd_reg[15:8];
          if (crc8_update(crc8_update(8'h00, id), val) == cmd_reg[7:0]) begin
            r.kind = KIND_CMD;
            r.cmd_id = id;
            r.cmd_value = val;
            due_results.push_back(r);
          end
          back_to_hunt();
        end
      end
      MODE_PAY: begin
        byte_reg = {byte_reg[6:0], b};
        bits_in_frame++;
        if (bits_in_frame % 8 == 0) begin
          idx = bits_in_frame / 8 - 1;
          r.kind = KIND_PAY;
          r.pay_byte = byte_reg ^ whiten_mask(idx);
          r.byte_index = idx[BYTE_IDX_W-1:0];
          r.last = (bits_in_frame >= FRAME_BYTES * 8);
          due_results.push_back(r);
          byte_reg = '0;
          if (r.last) back_to_hunt();
        end
      end
      default: begin
        sync_reg = {sync_reg[30:0], raw};
        if (sync_reg == cmd_sync) begin
          rx_mode = MODE_CMD;
          inv_flag = 1'b0;
        end else if (sync_reg == ~cmd_sync) begin
          rx_mode = MODE_CMD;
          inv_flag = 1'b1;
        end else if (sync_reg == pay_sync) begin
          rx_mode = MODE_PAY;
          inv_flag = 1'b0;
        end else if (sync_reg == ~pay_sync) begin
          rx_mode = MODE_PAY;
          inv_flag = 1'b1;
        end
        if (rx_mode != MODE_HUNT) begin
          bits_in_frame = 0;
          cmd_reg = '0;
          byte_reg = '0;
        end
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Sender: one bit per word, random gaps unless steady
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) deframe_bit(s_tdata[0]);
      if (!s_tvalid || s_tready) begin
        if (rx_bits.size() != 0 && (send_steady || $urandom_range(99) >= 15)) begin
          s_tvalid <= 1'b1;
          s_tdata <= {7'd0, rx_bits.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= recv_steady || ($urandom_range(99) >= 15);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result word with none expected: tdata %h tuser %b tlast %b",
               m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", want.kind, m_tuser[0]);
        check_field("command_id", want.cmd_id, m_tdata[7:0]);
        check_field("command_value", want.cmd_value, m_tdata[15:8]);
        check_field("payload_byte", want.pay_byte, m_tdata[23:16]);
        check_field("byte_index", want.byte_index, m_tdata[29:24]);
        check_field("last_byte", want.last, m_tlast);
        check_field("frame_inverted", want.inverted, m_tuser[1]);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic void push_bits(input logic [31:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) rx_bits.push_back(v[k]);
  endfunction

  function automatic void send_command(input logic [7:0] id, input logic [7:0] val,
                                       input bit crc_good, input bit inverted);
    logic [7:0]  crc;
    logic [23:0] body;
    crc = crc8_update(crc8_update(8'h00, id), val);
    if (!crc_good) crc = crc ^ 8'($urandom_range(1, 255));
    body = {id, val, crc};
    push_bits(inverted ? ~cmd_sync : cmd_sync, 32);
    push_bits(inverted ? ~body : body, 24);
    frame_bits_sent += 56;
  endfunction

  function automatic void send_payload(input bit inverted, input body_style_t style);
    logic [7:0] raw;
    push_bits(inverted ? ~pay_sync : pay_sync, 32);
    for (int unsigned i = 0; i < FRAME_BYTES; i++) begin
      case (style)
        BODY_EXTREMES:    raw = whiten_mask(i) ^ ((i % 2) ? 8'hFF : 8'h00);
        BODY_SYNC_INSIDE: raw = (i < 4) ? cmd_sync[31 - 8*i -: 8] : 8'($urandom);
        default:          raw = 8'($urandom);
      endcase
      push_bits(inverted ? ~raw : raw, 8);
    end
    frame_bits_sent += 32 + FRAME_BYTES * 8;
  endfunction

  // Command frames with random content, well-formed and broken, and noise
  function automatic void random_traffic(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = frame_bits_sent;
    while (frame_bits_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_command(8'($urandom), 8'($urandom), 1'b1, 1'($urandom_range(1)));
      else if (pick < 70)
        send_command(8'($urandom), 8'($urandom), 1'b0, 1'($urandom_range(1)));
      else
        push_bits($urandom, $urandom_range(1, 32));
    end
  endfunction

  // Wait until every bit is taken and every result word has arrived
  task automatic drain();
    while (rx_bits.size() != 0 || s_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_words(input logic [31:0] cmd_w, input logic [31:0] pay_w);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_CMD_SYNC;
    cfg_data <= cmd_w;
    @(posedge clk);
    cfg_index <= REG_PAY_SYNC;
    cfg_data <= pay_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    cmd_sync = cmd_w;
    pay_sync = pay_w;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    logic [31:0] w;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames at the reset sync words
    send_command(8'h00, 8'h00, 1'b1, 1'b0);
    send_command(8'hFF, 8'hFF, 1'b1, 1'b1);
    send_command(8'h5A, 8'h3C, 1'b0, 1'b0);
    send_command(8'hA5, 8'hC3, 1'b0, 1'b1);
    send_payload(1'b0, BODY_EXTREMES);
    drain();

    // Receiver holds off while the sender keeps offering a payload frame
    send_steady = 1'b1;
    send_payload(1'b1, BODY_SYNC_INSIDE);
    hold_req++;
    drain();
    send_steady = 1'b0;
    random_traffic(20);

    // Equal words: command takes precedence
    w = $urandom;
    set_words(w, w);
    send_command(8'($urandom), 8'($urandom), 1'b1, 1'b0);
    send_command(8'($urandom), 8'($urandom), 1'b1, 1'b1);
    random_traffic(20);

    // Random words, no idling on either side
    set_words($urandom, $urandom);
    send_steady = 1'b1;
    recv_steady = 1'b1;
    random_traffic(60);
    drain();
    send_steady = 1'b0;
    recv_steady = 1'b0;

    // Extremes
    set_words(32'h0000_0000, 32'hFFFF_FFFF);
    random_traffic(20);
    set_words($urandom, 32'h0000_0000);
    random_traffic(20);
    set_words(32'hFFFF_FFFF, $urandom);
    random_traffic(20);

    // Payload word equal to the inverse command word
    w = $urandom;
    set_words(w, ~w);
    random_traffic(20);

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
